@@ src/pdlr_pkg.sv @@
// Shared types, constants and the sequencer program ROM of the PCM downmix resampler.
package pdlr_pkg;

   // Transaction payloads.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mono_sample;
      logic               clip_end;
   } rsp_type;

   // A completed frame, reported by the unpacker for the byte being accepted.
   typedef struct packed {
      logic               done;
      logic signed [15:0] mono;
   } frame_type;

   // Register map, indexed by paddr[3:2].
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_WIDTH_MODE = 2'd0;
   localparam reg_index_type REG_CHANNELS   = 2'd1;
   localparam reg_index_type REG_RATE       = 2'd2;

   localparam logic        WIDTH_8BIT     = 1'b0;
   localparam logic        RESET_MODE     = 1'b1;
   localparam logic [1:0]  RESET_CHANNELS = 2'd1;
   localparam logic [1:0]  STEREO_COUNT   = 2'd2;
   localparam logic [16:0] RESET_RATE     = 17'd22050;
   localparam logic [16:0] RATE_MIN       = 17'd8000;
   localparam logic [16:0] RATE_MAX       = 17'd96000;

   // Output rate on the phase scale and helpers for the fraction.
   localparam logic [17:0]        MIXER_PHASE = 18'd44100;
   localparam logic [17:0]        TWO_MIXER   = 18'd88200;
   localparam logic [31:0]        MIXER_REM   = 32'd44100;
   localparam logic signed [17:0] MIXER_MUL   = 18'sd44100;
   // floor(2^32 / 44100): the estimate of r*65536/44100 is low by at most one.
   localparam logic signed [17:0] RECIP_MUL   = 18'sd97391;

   // Microcode.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_PUSH_TENT,
      OP_MUL_RECIP,
      OP_LOAD_QEST,
      OP_MUL_QK,
      OP_FIX_FRAC,
      OP_MUL_DIFF,
      OP_INTERP,
      OP_PUSH_VAL,
      OP_END_FRAME,
      OP_FIRST_FRAME,
      OP_CLR_TENT,
      OP_PUSH_PREV,
      OP_EMIT_END
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_PREV,
      COND_NOT_LAST,
      COND_PHASE_WRAP,
      COND_FLUSH_DONE
   } cond_type;

   typedef logic [4:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   localparam step_type S_IDLE   = 5'd0;
   localparam step_type S_FRAME  = 5'd1;
   localparam step_type S_TENT   = 5'd2;
   localparam step_type S_LOOP   = 5'd3;
   localparam step_type S_MREC   = 5'd4;
   localparam step_type S_QEST   = 5'd5;
   localparam step_type S_MQK    = 5'd6;
   localparam step_type S_FIX    = 5'd7;
   localparam step_type S_MDIF   = 5'd8;
   localparam step_type S_INTERP = 5'd9;
   localparam step_type S_PUSHV  = 5'd10;
   localparam step_type S_ENDF   = 5'd11;
   localparam step_type S_GOFL   = 5'd12;
   localparam step_type S_FIRST  = 5'd13;
   localparam step_type S_FLUSH  = 5'd14;
   localparam step_type S_FLOOP  = 5'd15;
   localparam step_type S_FPUSH  = 5'd16;
   localparam step_type S_FEND   = 5'd17;

   // Program ROM: the jump is taken when the condition holds, else the next step follows.
   function automatic ctrl_type pdlr_rom(input step_type step);
      ctrl_type cw;
      cw = '{op: OP_NOP, cond: COND_ALWAYS, target: S_IDLE};
      case (step)
         S_IDLE:   cw = '{op: OP_NOP,         cond: COND_NEVER,      target: S_IDLE};
         S_FRAME:  cw = '{op: OP_NOP,         cond: COND_NO_PREV,    target: S_FIRST};
         S_TENT:   cw = '{op: OP_PUSH_TENT,   cond: COND_NEVER,      target: S_IDLE};
         S_LOOP:   cw = '{op: OP_NOP,         cond: COND_PHASE_WRAP, target: S_ENDF};
         S_MREC:   cw = '{op: OP_MUL_RECIP,   cond: COND_NEVER,      target: S_IDLE};
         S_QEST:   cw = '{op: OP_LOAD_QEST,   cond: COND_NEVER,      target: S_IDLE};
         S_MQK:    cw = '{op: OP_MUL_QK,      cond: COND_NEVER,      target: S_IDLE};
         S_FIX:    cw = '{op: OP_FIX_FRAC,    cond: COND_NEVER,      target: S_IDLE};
         S_MDIF:   cw = '{op: OP_MUL_DIFF,    cond: COND_NEVER,      target: S_IDLE};
         S_INTERP: cw = '{op: OP_INTERP,      cond: COND_NEVER,      target: S_IDLE};
         S_PUSHV:  cw = '{op: OP_PUSH_VAL,    cond: COND_ALWAYS,     target: S_LOOP};
         S_ENDF:   cw = '{op: OP_END_FRAME,   cond: COND_NOT_LAST,   target: S_IDLE};
         S_GOFL:   cw = '{op: OP_NOP,         cond: COND_ALWAYS,     target: S_FLUSH};
         S_FIRST:  cw = '{op: OP_FIRST_FRAME, cond: COND_NOT_LAST,   target: S_IDLE};
         S_FLUSH:  cw = '{op: OP_CLR_TENT,    cond: COND_NO_PREV,    target: S_FEND};
         S_FLOOP:  cw = '{op: OP_NOP,         cond: COND_FLUSH_DONE, target: S_FEND};
         S_FPUSH:  cw = '{op: OP_PUSH_PREV,   cond: COND_ALWAYS,     target: S_FLOOP};
         S_FEND:   cw = '{op: OP_EMIT_END,    cond: COND_ALWAYS,     target: S_IDLE};
         default:  cw = '{op: OP_NOP,         cond: COND_ALWAYS,     target: S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

@@ src/pdlr_frame_unpack.sv @@
// Byte to frame assembly: sample building, stereo hold and downmix to mono.
module pdlr_frame_unpack (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                clear,
   input  logic [7:0]          data_byte,
   input  logic                width_mode,
   input  logic                stereo,
   output pdlr_pkg::frame_type frame
);
   import pdlr_pkg::*;

   logic [1:0]         pos_ff, pos_in;
   logic [7:0]         low_ff, low_in;
   logic signed [15:0] first_ff, first_in;
   logic signed [15:0] sample;
   logic signed [16:0] sum;
   logic               sample_done;
   logic [1:0]         slot;

   always_comb begin
      sample_done = 1'b0;
      sample      = '0;
      slot        = pos_ff;
      pos_in      = pos_ff;
      low_in      = low_ff;
      first_in    = first_ff;
      frame       = '0;

      if (width_mode == WIDTH_8BIT) begin
         // Unsigned byte, recentred and scaled by 256.
         sample      = {~data_byte[7], data_byte[6:0], 8'h00};
         sample_done = 1'b1;
      end else begin
         slot = {1'b0, pos_ff[1]};
         if (!pos_ff[0]) begin
            low_in = data_byte;
            pos_in = pos_ff + 2'd1;
         end else begin
            sample      = {data_byte, low_ff};
            sample_done = 1'b1;
         end
      end

      sum = {first_ff[15], first_ff} + {sample[15], sample};

      if (sample_done) begin
         if (stereo && slot == 2'd0) begin
            first_in = sample;
            pos_in   = pos_ff + 2'd1;
         end else begin
            frame.done = 1'b1;
            frame.mono = stereo ? sum[16:1] : sample;
            pos_in     = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pos_ff   <= '0;
         low_ff   <= '0;
         first_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         low_ff   <= low_in;
         first_ff <= first_in;
      end
   end

endmodule

@@ src/pcm_downmix_linear_resampler_core.sv @@
// Top level of the PCM downmix and linear resampler: register port, sequencer and datapath.
//
//   Channel   Ports                                   Transaction
//   -------   -------------------------------------   ------------------------------------
//   request   req_valid, req_ready, req_data          one clip byte and its last mark
//   response  rsp_valid, rsp_ready, rsp_data          one 44100 Hz mono sample, end mark
//   control   psel, penable, pwrite, paddr, pwdata,   register write or read, zero wait
//             prdata, pready
//
// A byte that does not complete a frame and is not the last is absorbed at the idle step. A byte
// that completes a frame keeps the sequencer busy while it interpolates the outputs that fall in
// the frame, the fraction and the interpolation sharing a single 18x18 multiplier over six steps.
// A flush repeats the last frame's sample while the phase allows and then marks the end, and goes
// straight to its end step when the clip holds no whole frame. Reset is synchronous and clears the
// stream state and the registers to 16-bit mono at 22050 Hz. A stalled response only holds the
// step that must hand a sample to the output register; req_ready is high whenever the sequencer
// sits at its idle step, even while a finished response still waits.
module pcm_downmix_linear_resampler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pdlr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pdlr_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import pdlr_pkg::*;

   // Configuration registers.
   logic        mode_ff, mode_in;
   logic [1:0]  chan_ff, chan_in;
   logic [16:0] rate_ff, rate_in;
   logic [16:0] rate_eff;
   logic        stereo;
   logic        cfg_write;

   // Sequencer and stream control state.
   step_type pc_ff, pc_in;
   logic     last_ff, last_in;
   logic     have_prev_ff, have_prev_in;
   logic [17:0] phase_ff, phase_in;
   logic     pend_valid_ff, pend_valid_in;
   logic     tent_valid_ff, tent_valid_in;
   logic     rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [15:0] cur_ff, cur_in;
   logic signed [15:0] prev_ff, prev_in;
   logic signed [15:0] pend_ff, pend_in;
   logic signed [15:0] tent_ff, tent_in;
   logic signed [15:0] val_ff, val_in;
   logic [15:0]        frac_ff, frac_in;
   logic signed [35:0] prod_ff, prod_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Sequencer decode and datapath helpers.
   ctrl_type           cw;
   frame_type          frame;
   logic               req_accept;
   logic               busy;
   logic               out_free;
   logic               need_emit;
   logic               stall;
   logic               take;
   logic               clear_stream;
   logic               push_en;
   logic signed [15:0] push_value;
   logic               emit_en;
   rsp_type            emit_data;
   logic               push_now;
   logic [17:0]        rate_sum;
   logic signed [17:0] mul_a, mul_b;
   logic signed [16:0] diff;
   logic [31:0]        rem;

   assign pready     = 1'b1;
   assign cfg_write  = psel && penable && pwrite && pready;
   assign stereo     = (chan_ff == STEREO_COUNT);
   assign busy       = (pc_ff != S_IDLE);
   assign req_ready  = !busy;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // The rate register is used clamped to the supported range.
   always_comb begin
      if (rate_ff < RATE_MIN) begin
         rate_eff = RATE_MIN;
      end else if (rate_ff > RATE_MAX) begin
         rate_eff = RATE_MAX;
      end else begin
         rate_eff = rate_ff;
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[3:2]))
         REG_WIDTH_MODE: prdata = {31'd0, mode_ff};
         REG_CHANNELS:   prdata = {30'd0, chan_ff};
         REG_RATE:       prdata = {15'd0, rate_ff};
         default:        prdata = '0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      chan_in = chan_ff;
      rate_in = rate_ff;
      if (cfg_write) begin
         case (reg_index_type'(paddr[3:2]))
            REG_WIDTH_MODE: mode_in = pwdata[0];
            REG_CHANNELS:   chan_in = pwdata[1:0];
            REG_RATE:       rate_in = pwdata[16:0];
            default:        mode_in = mode_ff;
         endcase
      end
   end

   pdlr_frame_unpack u_unpack (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .clear      (clear_stream),
      .data_byte  (req_data.data_byte),
      .width_mode (mode_ff),
      .stereo     (stereo),
      .frame      (frame)
   );

   // Sequencer and datapath.
   always_comb begin
      cw       = pdlr_rom(pc_ff);
      rate_sum = phase_ff + {1'b0, rate_eff};
      push_now = (rate_sum <= TWO_MIXER);
      out_free = !rsp_valid_ff || rsp_ready;
      diff     = {cur_ff[15], cur_ff} - {prev_ff[15], prev_ff};
      rem      = {phase_ff[15:0], 16'h0000} - prod_ff[31:0];

      case (cw.op)
         OP_PUSH_TENT: need_emit = tent_valid_ff && pend_valid_ff;
         OP_PUSH_VAL:  need_emit = push_now && pend_valid_ff;
         OP_PUSH_PREV: need_emit = pend_valid_ff;
         OP_EMIT_END:  need_emit = pend_valid_ff;
         default:      need_emit = 1'b0;
      endcase
      stall = need_emit && !out_free;

      case (cw.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_NO_PREV:    take = !have_prev_ff;
         COND_NOT_LAST:   take = !last_ff;
         COND_PHASE_WRAP: take = (phase_ff >= MIXER_PHASE);
         COND_FLUSH_DONE: take = (rate_sum > MIXER_PHASE);
         default:         take = 1'b0;
      endcase

      pc_in         = pc_ff;
      last_in       = last_ff;
      have_prev_in  = have_prev_ff;
      phase_in      = phase_ff;
      pend_valid_in = pend_valid_ff;
      tent_valid_in = tent_valid_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      pend_in       = pend_ff;
      tent_in       = tent_ff;
      val_in        = val_ff;
      frac_in       = frac_ff;
      prod_in       = prod_ff;
      mul_a         = '0;
      mul_b         = '0;
      push_en       = 1'b0;
      push_value    = val_ff;
      emit_en       = 1'b0;
      emit_data     = '0;
      clear_stream  = 1'b0;

      if (!busy) begin
         if (req_accept) begin
            last_in = req_data.last_byte;
            if (frame.done) begin
               cur_in = frame.mono;
               pc_in  = S_FRAME;
            end else if (req_data.last_byte) begin
               pc_in = S_FLUSH;
            end
         end
      end else if (!stall) begin
         pc_in = take ? cw.target : pc_ff + 5'd1;
         case (cw.op)
            OP_PUSH_TENT: begin
               if (tent_valid_ff) begin
                  push_en    = 1'b1;
                  push_value = tent_ff;
               end
               tent_valid_in = 1'b0;
            end
            OP_MUL_RECIP: begin
               mul_a   = $signed({2'b00, phase_ff[15:0]});
               mul_b   = RECIP_MUL;
               prod_in = mul_a * mul_b;
            end
            OP_LOAD_QEST: begin
               frac_in = prod_ff[31:16];
            end
            OP_MUL_QK: begin
               mul_a   = $signed({2'b00, frac_ff});
               mul_b   = MIXER_MUL;
               prod_in = mul_a * mul_b;
            end
            OP_FIX_FRAC: begin
               // The estimate is at most one low; the remainder tells.
               if (rem >= MIXER_REM) begin
                  frac_in = frac_ff + 16'd1;
               end
            end
            OP_MUL_DIFF: begin
               mul_a   = {diff[16], diff};
               mul_b   = $signed({2'b00, frac_ff});
               prod_in = mul_a * mul_b;
            end
            OP_INTERP: begin
               // The arithmetic shift floors; the sum always lies between the two samples.
               val_in = prev_ff + prod_ff[31:16];
            end
            OP_PUSH_VAL: begin
               // An output whose next step lands past the following frame stays tentative.
               if (push_now) begin
                  push_en    = 1'b1;
                  push_value = val_ff;
               end else begin
                  tent_in       = val_ff;
                  tent_valid_in = 1'b1;
               end
               phase_in = rate_sum;
            end
            OP_END_FRAME: begin
               phase_in = phase_ff - MIXER_PHASE;
               prev_in  = cur_ff;
            end
            OP_FIRST_FRAME: begin
               prev_in      = cur_ff;
               have_prev_in = 1'b1;
               phase_in     = '0;
            end
            OP_CLR_TENT: begin
               tent_valid_in = 1'b0;
            end
            OP_PUSH_PREV: begin
               push_en    = 1'b1;
               push_value = prev_ff;
               phase_in   = rate_sum;
            end
            OP_EMIT_END: begin
               if (pend_valid_ff) begin
                  emit_en   = 1'b1;
                  emit_data = '{mono_sample: pend_ff, clip_end: 1'b1};
               end
               clear_stream  = 1'b1;
               have_prev_in  = 1'b0;
               phase_in      = '0;
               pend_valid_in = 1'b0;
               tent_valid_in = 1'b0;
               last_in       = 1'b0;
            end
            default: begin
               pc_in = take ? cw.target : pc_ff + 5'd1;
            end
         endcase
      end

      // One sample is always held back so that the last one can carry the end mark.
      if (push_en) begin
         if (pend_valid_ff) begin
            emit_en   = 1'b1;
            emit_data = '{mono_sample: pend_ff, clip_end: 1'b0};
         end
         pend_in       = push_value;
         pend_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= RESET_MODE;
         chan_ff       <= RESET_CHANNELS;
         rate_ff       <= RESET_RATE;
         pc_ff         <= S_IDLE;
         last_ff       <= 1'b0;
         have_prev_ff  <= 1'b0;
         phase_ff      <= '0;
         pend_valid_ff <= 1'b0;
         tent_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         chan_ff       <= chan_in;
         rate_ff       <= rate_in;
         pc_ff         <= pc_in;
         last_ff       <= last_in;
         have_prev_ff  <= have_prev_in;
         phase_ff      <= phase_in;
         pend_valid_ff <= pend_valid_in;
         tent_valid_ff <= tent_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      pend_ff     <= pend_in;
      tent_ff     <= tent_in;
      val_ff      <= val_in;
      frac_ff     <= frac_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
